// ----- rtl/epr_pkg.sv -----
// Package for the echo pulse ranger: request codes, register indexes,
// queue entry layout and the structs passed between the ranger and the queue.
// No dependencies.
package epr_pkg;

   // Request codes on req_cmd.
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_TRIGGER = 2'd1;
   localparam logic [1:0] CMD_READ    = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_TICKS = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS = 4'd1;
   localparam int unsigned CSR_DATA_W = 32;

   localparam int unsigned TRIG_W  = 16;
   localparam int unsigned TMO_W   = 24;
   localparam int unsigned WIDTH_W = 32;
   localparam int unsigned COUNT_W = 7;

   localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RESET = 16'd20;
   localparam logic [TMO_W-1:0]  TIMEOUT_TICKS_RESET = 24'd50000;
   localparam logic [WIDTH_W-1:0] WIDTH_MAX = 32'hFFFF_FFFF;

   // Queue entry: timeout flag above the echo width.
   localparam int unsigned ENTRY_W = WIDTH_W + 1;

   typedef struct packed {
      logic                tmo;
      logic [WIDTH_W-1:0]  width;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

endpackage

// ----- rtl/epr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module epr_ram #(
   parameter int unsigned WIDTH = 33,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/epr_ranger.sv -----
// Trigger pulse, timeout and echo width measurement for the ranger.
// Depends on epr_pkg.
module epr_ranger
   import epr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          cmd,
   input  logic                echo_level,
   input  logic [TRIG_W-1:0]   trigger_ticks,
   input  logic [TMO_W-1:0]    timeout_ticks,
   output push_type            push,
   output logic                trigger_level
);

   logic [TRIG_W-1:0]  trigger_left_ff, trigger_left_in;
   logic [TMO_W-1:0]   timeout_left_ff, timeout_left_in;
   logic               timeout_armed_ff, timeout_armed_in;
   logic               echo_previous_ff, echo_previous_in;
   logic               measuring_ff, measuring_in;
   logic [WIDTH_W-1:0] width_count_ff, width_count_in;

   always_comb begin
      trigger_left_in  = trigger_left_ff;
      timeout_left_in  = timeout_left_ff;
      timeout_armed_in = timeout_armed_ff;
      echo_previous_in = echo_previous_ff;
      measuring_in     = measuring_ff;
      width_count_in   = width_count_ff;
      push             = '0;
      case (cmd)
         CMD_TICK: begin
            if (trigger_left_ff != '0) begin
               trigger_left_in = trigger_left_ff - TRIG_W'(1);
            end
            if (echo_level && !echo_previous_ff) begin
               measuring_in   = 1'b1;
               width_count_in = WIDTH_W'(1);
            end else if (echo_level && measuring_ff) begin
               if (width_count_ff != WIDTH_MAX) begin
                  width_count_in = width_count_ff + WIDTH_W'(1);
               end
            end else if (!echo_level && echo_previous_ff && measuring_ff) begin
               measuring_in           = 1'b0;
               timeout_armed_in       = 1'b0;
               timeout_left_in        = '0;
               push.valid             = 1'b1;
               push.entry.tmo         = 1'b0;
               push.entry.width       = width_count_ff;
               width_count_in         = '0;
            end
            echo_previous_in = echo_level;
            // A falling edge on this tick has already disarmed the timeout.
            if (timeout_armed_in) begin
               if (timeout_left_in <= TMO_W'(1)) begin
                  timeout_armed_in = 1'b0;
                  timeout_left_in  = '0;
                  push.valid       = 1'b1;
                  push.entry.tmo   = 1'b1;
                  push.entry.width = '0;
               end else begin
                  timeout_left_in = timeout_left_in - TMO_W'(1);
               end
            end
         end
         CMD_TRIGGER: begin
            trigger_left_in  = trigger_ticks;
            timeout_left_in  = timeout_ticks;
            timeout_armed_in = 1'b1;
         end
         default: begin
         end
      endcase
      if (!accept) begin
         push.valid = 1'b0;
      end
   end

   assign trigger_level = (trigger_left_in != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_left_ff  <= '0;
         timeout_left_ff  <= '0;
         timeout_armed_ff <= 1'b0;
         echo_previous_ff <= 1'b0;
         measuring_ff     <= 1'b0;
         width_count_ff   <= '0;
      end else if (accept) begin
         trigger_left_ff  <= trigger_left_in;
         timeout_left_ff  <= timeout_left_in;
         timeout_armed_ff <= timeout_armed_in;
         echo_previous_ff <= echo_previous_in;
         measuring_ff     <= measuring_in;
         width_count_ff   <= width_count_in;
      end
   end

`ifndef ASSERT_OFF
   a_idle_width_zero: assert property (@(posedge clock) disable iff (reset)
      !measuring_ff |-> width_count_ff == '0)
      else $error("width count is nonzero while no echo is measured");

   a_disarmed_left_zero: assert property (@(posedge clock) disable iff (reset)
      !timeout_armed_ff |-> timeout_left_ff == '0)
      else $error("timeout count left over after the timeout was disarmed");
`endif

endmodule

// ----- rtl/epr_queue.sv -----
// Result queue of the ranger: ring pointers around a RAM with registered read.
// Depends on epr_pkg and epr_ram.
module epr_queue
   import epr_pkg::*;
#(
   parameter int unsigned DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               pop_req,
   input  push_type           push,
   output logic               pop_valid,
   output entry_type          pop_entry,
   output logic [COUNT_W-1:0] count
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] wr_next, rd_next;
   logic             do_push, do_pop;
   logic [PTR_W:0]   fill;
   logic [PTR_W+COUNT_W:0] fill_wide;
   logic [ENTRY_W-1:0] rd_data;

   assign wr_next = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_next = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);

   // A push into a full ring is dropped.
   assign do_push   = push.valid && (wr_next != rd_ptr_ff);
   assign do_pop    = accept && pop_req && (rd_ptr_ff != wr_ptr_ff);
   assign pop_valid = do_pop;

   assign wr_ptr_in = do_push ? wr_next : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_next : rd_ptr_ff;

   always_comb begin
      if (wr_ptr_in >= rd_ptr_in) begin
         fill = {1'b0, wr_ptr_in} - {1'b0, rd_ptr_in};
      end else begin
         fill = (PTR_W+1)'(DEPTH) - {1'b0, rd_ptr_in} + {1'b0, wr_ptr_in};
      end
   end

   assign fill_wide = {{COUNT_W{1'b0}}, fill};
   assign count     = fill_wide[COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   epr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (wr_ptr_ff),
      .wr_data (push.entry),
      .rd_en   (do_pop),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   assign pop_entry = entry_type'(rd_data);

`ifndef ASSERT_OFF
   a_no_push_and_pop: assert property (@(posedge clock) disable iff (reset)
      !(do_push && do_pop))
      else $error("queue pushed and popped for one request");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      do_pop |=> rd_ptr_ff != $past(rd_ptr_ff))
      else $error("pop did not advance the read pointer");
`endif

endmodule

// ----- rtl/echo_pulse_ranger_fifo.sv -----
// Ultrasonic echo ranger with a result queue, top level.
// Request channel req_*, response channel rsp_*, register write port csr_*.
// Each request gives exactly one response, in order. A tick request samples
// the echo pin and advances the trigger pulse and the timeout; a trigger
// request starts the trigger pulse and (re)arms the timeout; a read request
// pops the oldest queued echo width or timeout mark.
// Timing: the edge that accepts a request updates the state, loads the
// request stage and reads the queue RAM; the response register is loaded from
// the stage when it advances, which rsp_stall can hold off, and drives rsp_*.
// One request is taken every cycle while req_stall is low.
// Back pressure: a request stage and a response register sit between the
// channels, so a new request is still taken while one response waits under
// rsp_stall. req_stall rises only when both are full and rsp_stall is high.
// Reset clears ranger state, valid flags and queue pointers and loads default
// register values (trigger 20 ticks, timeout 50000 ticks). Queue RAM is not
// cleared; only written entries are ever read. csr_ready is always high; the
// user must write registers only while no request is in flight (unenforced).
// Depends on epr_pkg, epr_ranger, epr_queue and epr_ram.
module echo_pulse_ranger_fifo
   import epr_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_cmd,
   input  logic                   req_echo_level,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_trigger_level,
   output logic                   rsp_read_valid,
   output logic [WIDTH_W-1:0]     rsp_read_width,
   output logic                   rsp_read_timeout,
   output logic [COUNT_W-1:0]     rsp_queue_count,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [TRIG_W-1:0]  trigger_ticks_ff;
   logic [TMO_W-1:0]   timeout_ticks_ff;

   logic               accept;
   push_type           push;
   logic               trig_level;
   logic               pop_valid;
   entry_type          pop_entry;
   logic [COUNT_W-1:0] count;

   logic               stage_valid_ff, stage_valid_in;
   logic               stage_trig_ff;
   logic               stage_pop_ff;
   logic [COUNT_W-1:0] stage_count_ff;
   logic               stage_advance;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_trig_ff;
   logic               rsp_pop_ff;
   logic [WIDTH_W-1:0] rsp_width_ff;
   logic               rsp_tmo_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ticks_ff <= TRIGGER_TICKS_RESET;
         timeout_ticks_ff <= TIMEOUT_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TRIGGER_TICKS: trigger_ticks_ff <= csr_wdata[TRIG_W-1:0];
            CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wdata[TMO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Request stage and response register form a two-deep pipeline.
   assign stage_advance = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall     = stage_valid_ff && !stage_advance;
   assign accept        = req_valid && !req_stall;

   epr_ranger u_ranger (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .cmd           (req_cmd),
      .echo_level    (req_echo_level),
      .trigger_ticks (trigger_ticks_ff),
      .timeout_ticks (timeout_ticks_ff),
      .push          (push),
      .trigger_level (trig_level)
   );

   epr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .pop_req   (req_cmd == CMD_READ),
      .push      (push),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .count     (count)
   );

   assign stage_valid_in = accept ? 1'b1 : (stage_advance ? 1'b0 : stage_valid_ff);
   assign rsp_valid_in   = stage_advance ? 1'b1 :
                           ((rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_trig_ff  <= trig_level;
         stage_pop_ff   <= pop_valid;
         stage_count_ff <= count;
      end
      // The RAM read data belongs to the request in the stage register.
      if (stage_advance) begin
         rsp_trig_ff  <= stage_trig_ff;
         rsp_pop_ff   <= stage_pop_ff;
         rsp_tmo_ff   <= stage_pop_ff && pop_entry.tmo;
         rsp_width_ff <= (stage_pop_ff && !pop_entry.tmo) ? pop_entry.width : '0;
         rsp_count_ff <= stage_count_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_trigger_level = rsp_trig_ff;
   assign rsp_read_valid    = rsp_pop_ff;
   assign rsp_read_width    = rsp_width_ff;
   assign rsp_read_timeout  = rsp_tmo_ff;
   assign rsp_queue_count   = rsp_count_ff;

`ifndef ASSERT_OFF
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stage_valid_ff && rsp_valid_ff)
      else $error("request stalled with room in the pipeline");

   a_timeout_has_no_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_tmo_ff |-> rsp_pop_ff && rsp_width_ff == '0)
      else $error("timeout response carries a width or no pop");

   a_no_pop_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_pop_ff |-> !rsp_tmo_ff && rsp_width_ff == '0)
      else $error("response without a pop carries queue data");
`endif

endmodule
